### hw/rtl/ffha_pkg.sv
`timescale 1ns / 1ps

package ffha_pkg;

	localparam int HEAP_BYTES_DEF   = 4096;
	localparam int HEADER_BYTES_DEF = 16;

	localparam int OPCODE_W = 1;
	localparam int REQ_W    = 13;
	localparam int OFF_W    = 16;
	localparam int STATUS_W = 3;
	localparam int PAYLD_W  = 13;

	localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b0;
	localparam logic [OPCODE_W-1:0] OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_OOM       = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DOUBLE    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_START = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_HEAP  = 3'd4;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [REQ_W-1:0]    request_bytes;
		logic [OFF_W-1:0]    release_offset;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PAYLD_W-1:0]  payload_offset;
	} rsp_t;

endpackage

### hw/rtl/first_fit_heap_allocator.sv
`timescale 1ns / 1ps

// First-fit heap allocator over an implicit list of chunk headers.
// A request transaction enters on req_valid/req_stall and carries an opcode
// (allocate or free), a byte count and a release offset. Every request yields
// exactly one response transaction on rsp_valid/rsp_stall with a status and,
// for a granted allocation, the payload offset.
// The headers live in one synchronous RAM with one read and one write port.
// A request visits the chunks from offset 0, one header read per cycle, so
// the RAM read port sets the pace. A split or a merge needs a second header
// write or read in the SPLIT or MERGE state before the response is loaded
// into the output register from the DONE state.
// One request is worked on at a time; req_stall is high while it is in
// flight, and a new request is taken as soon as the previous response sits
// in the output register, even if the receiver has not taken it yet.
// While rsp_stall holds a response, a finished result waits and the next
// request does not start until the output register is free.
// After reset, the INIT state writes the header of the single free chunk that
// covers the whole heap; req_stall is high while it does.

module first_fit_heap_allocator #(
	parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
	parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  ffha_pkg::req_t  req_data,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output ffha_pkg::rsp_t  rsp_data
);

	localparam int AW = $clog2(HEAP_BYTES);
	localparam int CW = (AW + 2 > ffha_pkg::OFF_W + 1) ? AW + 2 : ffha_pkg::OFF_W + 1;

	localparam logic [CW-1:0] HDR_C  = CW'(HEADER_BYTES);
	localparam logic [CW-1:0] HEAP_C = CW'(HEAP_BYTES);

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_WALK  = 3'd2;
	localparam logic [2:0] S_SPLIT = 3'd3;
	localparam logic [2:0] S_MERGE = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	typedef struct packed {
		logic          used;
		logic [AW-1:0] size;
	} hdr_t;

	logic [2:0]                        state_q;
	logic [ffha_pkg::OPCODE_W-1:0]     op_q;
	logic [ffha_pkg::REQ_W-1:0]        req_bytes_q;
	logic [ffha_pkg::OFF_W-1:0]        off_q;
	logic [AW-1:0]                     pos_q;
	logic [AW-1:0]                     cur_size_q;
	logic [AW-1:0]                     split_pos_q;
	logic [AW-1:0]                     split_size_q;
	ffha_pkg::rsp_t                    res_q;
	logic                              rsp_valid_q;
	ffha_pkg::rsp_t                    rsp_q;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	hdr_t          wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	hdr_t          rd_data;

	logic          accept;
	logic [CW-1:0] pos_c;
	logic [CW-1:0] size_c;
	logic [CW-1:0] req_c;
	logic [CW-1:0] nxt_c;
	logic [CW-1:0] npos_c;
	logic          nxt_end;
	logic          fit;
	logic          split;
	logic          match;
	logic          out_free;
	logic [CW-1:0] merged_c;

	ffha_hdr_ram #(
		.DEPTH (HEAP_BYTES),
		.WIDTH (AW + 1)
	) u_hdr_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign accept   = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign out_free = !rsp_valid_q || !rsp_stall;

	assign pos_c    = CW'(pos_q);
	assign size_c   = CW'(rd_data.size);
	assign req_c    = CW'(req_bytes_q);
	assign nxt_c    = pos_c + HDR_C + size_c;
	assign npos_c   = pos_c + HDR_C + req_c;
	assign nxt_end  = (nxt_c >= HEAP_C);
	assign fit      = !rd_data.used && (req_c <= size_c);
	assign split    = ((size_c - req_c) > HDR_C) && (npos_c < HEAP_C);
	assign match    = ((pos_c + HDR_C) == CW'(off_q));
	assign merged_c = CW'(cur_size_q) + HDR_C + size_c;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = '{used: 1'b0, size: rd_data.size};
		rd_en   = 1'b0;
		rd_addr = nxt_c[AW-1:0];
		unique case (state_q)
			S_INIT: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = '{used: 1'b0, size: AW'(HEAP_BYTES - HEADER_BYTES)};
			end
			S_IDLE: begin
				rd_en   = accept;
				rd_addr = '0;
			end
			S_WALK: begin
				if (op_q == ffha_pkg::OP_ALLOC) begin
					if (fit) begin
						wr_en   = 1'b1;
						wr_data = '{used: 1'b1,
							size: split ? req_c[AW-1:0] : rd_data.size};
					end else begin
						rd_en = !nxt_end;
					end
				end else begin
					if (match) begin
						if (rd_data.used) begin
							if (nxt_end) begin
								wr_en = 1'b1;
							end else begin
								rd_en = 1'b1;
							end
						end
					end else begin
						rd_en = !nxt_end;
					end
				end
			end
			S_SPLIT: begin
				wr_en   = 1'b1;
				wr_addr = split_pos_q;
				wr_data = '{used: 1'b0, size: split_size_q};
			end
			S_MERGE: begin
				wr_en   = 1'b1;
				wr_data = '{used: 1'b0,
					size: rd_data.used ? cur_size_q : merged_c[AW-1:0]};
			end
			S_DONE: begin
				wr_en = 1'b0;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			unique case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (op_q == ffha_pkg::OP_ALLOC) begin
						if (fit) begin
							state_q <= split ? S_SPLIT : S_DONE;
						end else if (nxt_end) begin
							state_q <= S_DONE;
						end
					end else begin
						if (match) begin
							state_q <= (rd_data.used && !nxt_end) ? S_MERGE : S_DONE;
						end else if (nxt_end) begin
							state_q <= S_DONE;
						end
					end
				end
				S_SPLIT, S_MERGE: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= req_data.opcode;
			req_bytes_q <= req_data.request_bytes;
			off_q       <= req_data.release_offset;
			pos_q       <= '0;
		end
		if (state_q == S_WALK) begin
			cur_size_q   <= rd_data.size;
			split_pos_q  <= npos_c[AW-1:0];
			split_size_q <= rd_data.size - req_c[AW-1:0] - HDR_C[AW-1:0];
			if (op_q == ffha_pkg::OP_ALLOC) begin
				if (fit) begin
					res_q.status         <= ffha_pkg::ST_OK;
					res_q.payload_offset <= ffha_pkg::PAYLD_W'(pos_c + HDR_C);
				end else begin
					pos_q                <= nxt_c[AW-1:0];
					res_q.status         <= ffha_pkg::ST_OOM;
					res_q.payload_offset <= '0;
				end
			end else begin
				res_q.payload_offset <= '0;
				if (match) begin
					res_q.status <= rd_data.used ? ffha_pkg::ST_OK : ffha_pkg::ST_DOUBLE;
				end else begin
					pos_q <= nxt_c[AW-1:0];
					if ((off_q != '0) && (CW'(off_q) <= HEAP_C)) begin
						res_q.status <= ffha_pkg::ST_NOT_START;
					end else begin
						res_q.status <= ffha_pkg::ST_NOT_HEAP;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	a_accept_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_WALK))
		else $error("Accepted request did not start a header walk.");

	a_no_write_when_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |-> !wr_en)
		else $error("Header write outside of a working state.");

	a_split_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SPLIT || state_q == S_MERGE) |-> ($past(state_q) == S_WALK))
		else $error("Split or merge did not follow a header walk.");

	a_fail_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.status != ffha_pkg::ST_OK) |-> (rsp_data.payload_offset == '0))
		else $error("Failed request returned a nonzero payload offset.");

endmodule

### hw/rtl/ffha_hdr_ram.sv
`timescale 1ns / 1ps

module ffha_hdr_ram #(
	parameter int DEPTH = ffha_pkg::HEAP_BYTES_DEF,
	parameter int WIDTH = 13
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_s1;

endmodule

### tb/tb_first_fit_heap_allocator.sv
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator;
	import ffha_pkg::*;

	localparam int HEAP = HEAP_BYTES_DEF;
	localparam int HDR = HEADER_BYTES_DEF;
	localparam int RANDOM_ITEMS = 1300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD = 800;
	localparam int LIVE_CAP = 48;

	typedef struct {
		req_t rq;
		bit   fixed;
		rsp_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req_data;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp_data;

	int unsigned chunk_len [HEAP];
	bit          chunk_busy [HEAP];

	rsp_t             awaited_replies [$];
	logic [OFF_W-1:0] live_ptrs [$];
	logic [OFF_W-1:0] freed_ptrs [$];

	int   mismatches = 0;
	int   replies_taken = 0;
	int   quiet_cycles = 0;
	int   steady_left = 0;
	bit   long_hold_done = 1'b0;
	rsp_t want_rsp;

	// Rows with a fixed reply are checked against it; the others use the predictor.
	plan_row_t plan [24] = '{
		'{'{OP_FREE,  13'd0,    16'd0},     1'b1, '{ST_NOT_HEAP,  13'd0}},
		'{'{OP_FREE,  13'd0,    16'd16},    1'b1, '{ST_DOUBLE,    13'd0}},
		'{'{OP_FREE,  13'd0,    16'd4097},  1'b1, '{ST_NOT_HEAP,  13'd0}},
		'{'{OP_FREE,  13'd0,    16'd65535}, 1'b1, '{ST_NOT_HEAP,  13'd0}},
		'{'{OP_FREE,  13'd0,    16'd4096},  1'b1, '{ST_NOT_START, 13'd0}},
		'{'{OP_FREE,  13'd0,    16'd1},     1'b1, '{ST_NOT_START, 13'd0}},
		'{'{OP_ALLOC, 13'd8191, 16'd0},     1'b1, '{ST_OOM,       13'd0}},
		'{'{OP_ALLOC, 13'd4081, 16'd0},     1'b1, '{ST_OOM,       13'd0}},
		'{'{OP_ALLOC, 13'd0,    16'd0},     1'b1, '{ST_OK,        13'd16}},
		'{'{OP_ALLOC, 13'd4064, 16'd0},     1'b1, '{ST_OK,        13'd32}},
		'{'{OP_ALLOC, 13'd0,    16'd0},     1'b1, '{ST_OOM,       13'd0}},
		'{'{OP_FREE,  13'd0,    16'd32},    1'b1, '{ST_OK,        13'd0}},
		'{'{OP_FREE,  13'd0,    16'd32},    1'b1, '{ST_DOUBLE,    13'd0}},
		'{'{OP_FREE,  13'd0,    16'd16},    1'b1, '{ST_OK,        13'd0}},
		'{'{OP_FREE,  13'd0,    16'd24},    1'b1, '{ST_NOT_START, 13'd0}},
		'{'{OP_ALLOC, 13'd4080, 16'd0},     1'b1, '{ST_OK,        13'd16}},
		'{'{OP_FREE,  13'd0,    16'd16},    1'b1, '{ST_OK,        13'd0}},
		'{'{OP_ALLOC, 13'd4063, 16'd0},     1'b0, '{ST_OK,        13'd0}},
		'{'{OP_ALLOC, 13'd1,    16'd0},     1'b0, '{ST_OK,        13'd0}},
		'{'{OP_FREE,  13'd0,    16'd16},    1'b0, '{ST_OK,        13'd0}},
		'{'{OP_ALLOC, 13'd4064, 16'd0},     1'b0, '{ST_OK,        13'd0}},
		'{'{OP_ALLOC, 13'd4047, 16'd0},     1'b0, '{ST_OK,        13'd0}},
		'{'{OP_FREE,  13'd0,    16'd4095},  1'b0, '{ST_OK,        13'd0}},
		'{'{OP_FREE,  13'd0,    16'd16},    1'b0, '{ST_OK,        13'd0}}
	};

	first_fit_heap_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic rsp_t heap_outcome(req_t r);
		int unsigned pos;
		int unsigned want_len;
		int unsigned off;
		int unsigned nxt;
		rsp_t res;
		res.status = ST_OOM;
		res.payload_offset = '0;
		pos = 0;
		if (r.opcode == OP_ALLOC) begin
			want_len = r.request_bytes;
			while (pos < HEAP) begin
				if (!chunk_busy[pos] && want_len <= chunk_len[pos]) begin
					if (chunk_len[pos] - want_len > HDR) begin
						nxt = pos + HDR + want_len;
						if (nxt < HEAP) begin
							chunk_busy[nxt] = 1'b0;
							chunk_len[nxt] = chunk_len[pos] - want_len - HDR;
							chunk_len[pos] = want_len;
						end
					end
					chunk_busy[pos] = 1'b1;
					res.status = ST_OK;
					res.payload_offset = PAYLD_W'(pos + HDR);
					return res;
				end
				pos += HDR + chunk_len[pos];
			end
			return res;
		end
		off = r.release_offset;
		while (pos < HEAP) begin
			if (pos + HDR == off) begin
				if (!chunk_busy[pos]) begin
					res.status = ST_DOUBLE;
					return res;
				end
				chunk_busy[pos] = 1'b0;
				nxt = pos + HDR + chunk_len[pos];
				if (nxt < HEAP && !chunk_busy[nxt])
					chunk_len[pos] += HDR + chunk_len[nxt];
				res.status = ST_OK;
				return res;
			end
			pos += HDR + chunk_len[pos];
		end
		res.status = (off > 0 && off <= HEAP) ? ST_NOT_START : ST_NOT_HEAP;
		return res;
	endfunction

	function automatic int idle_len();
		int k;
		if (steady_left > 0) begin
			steady_left--;
			return 0;
		end
		k = $urandom_range(0, 99);
		if (k == 0) begin
			steady_left = $urandom_range(30, 100);
			return 0;
		end
		if (k < 50)
			return 0;
		if (k < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	task automatic issue(req_t r, bit fixed, rsp_t fixed_rsp, int gap);
		rsp_t model_rsp;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_data <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		model_rsp = heap_outcome(r);
		awaited_replies.push_back(fixed ? fixed_rsp : model_rsp);
		if (r.opcode == OP_ALLOC && model_rsp.status == ST_OK)
			live_ptrs.push_back(OFF_W'(model_rsp.payload_offset));
	endtask

	initial begin
		req_t item;
		int pick;
		int k;
		req_valid = 1'b0;
		req_data = '0;
		arst_n = 1'b0;
		for (int i = 0; i < HEAP; i++) begin
			chunk_len[i] = 0;
			chunk_busy[i] = 1'b0;
		end
		chunk_len[0] = HEAP - HDR;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i])
			issue(plan[i].rq, plan[i].fixed, plan[i].want, idle_len());

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			item.request_bytes = REQ_W'($urandom);
			item.release_offset = OFF_W'($urandom);
			pick = $urandom_range(0, 99);
			if (live_ptrs.size() >= LIVE_CAP && pick < 55)
				pick = 55 + pick % 35;
			if (pick < 55 || (pick < 90 && live_ptrs.size() == 0)) begin
				item.opcode = OP_ALLOC;
				k = $urandom_range(0, 19);
				if (k == 0)
					item.request_bytes = REQ_W'($urandom_range(0, 8191));
				else if (k < 5)
					item.request_bytes = REQ_W'($urandom_range(64, 600));
				else
					item.request_bytes = REQ_W'($urandom_range(0, 63));
			end else if (pick < 90) begin
				item.opcode = OP_FREE;
				k = $urandom_range(0, live_ptrs.size() - 1);
				item.release_offset = live_ptrs[k];
				live_ptrs.delete(k);
				freed_ptrs.push_back(item.release_offset);
				if (freed_ptrs.size() > 32)
					void'(freed_ptrs.pop_front());
			end else if (pick < 95 && freed_ptrs.size() != 0) begin
				item.opcode = OP_FREE;
				item.release_offset = freed_ptrs[$urandom_range(0, freed_ptrs.size() - 1)];
			end else begin
				item.opcode = OP_FREE;
				if ($urandom_range(0, 3) != 0)
					item.release_offset = OFF_W'($urandom_range(0, HEAP + 4));
			end
			issue(item, 1'b0, '0, idle_len());
			if (n == 650 || $urandom_range(0, 149) == 0) begin
				req_valid <= 1'b0;
				while (awaited_replies.size() != 0) @(posedge clk);
			end
		end
		req_valid <= 1'b0;

		while (awaited_replies.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && awaited_replies.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// The receiver mostly takes replies at once, but after enough traffic it holds
	// off for a long stretch once so that the block backs up into its input.
	initial begin
		int hold;
		rsp_stall = 1'b0;
		forever begin
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20))
				@(posedge clk);
			if (!long_hold_done && replies_taken >= 300) begin
				long_hold_done = 1'b1;
				hold = LONG_HOLD;
			end else if ($urandom_range(0, 9) == 0) begin
				hold = $urandom_range(20, 120);
			end else begin
				hold = $urandom_range(1, 3);
			end
			rsp_stall <= 1'b1;
			repeat (hold) @(posedge clk);
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			replies_taken++;
			if (awaited_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: status %0d offset %0d",
						rsp_data.status, rsp_data.payload_offset);
			end else begin
				want_rsp = awaited_replies.pop_front();
				if (rsp_data.status !== want_rsp.status ||
						rsp_data.payload_offset !== want_rsp.payload_offset) begin
					mismatches++;
					if (mismatches <= 10)
						$display("transaction %0d: expected status %0d offset %0d, got status %0d offset %0d",
							replies_taken, want_rsp.status, want_rsp.payload_offset,
							rsp_data.status, rsp_data.payload_offset);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

endmodule

### filelist.f
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_hdr_ram.sv
hw/rtl/first_fit_heap_allocator.sv
tb/tb_first_fit_heap_allocator.sv
